FILE: src/resc_pkg.sv
`timescale 1ns / 1ps

package resc_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_EXHAUSTED   = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_HEADER = 1'b1;

    localparam logic [1:0] CFG_MAX_HEADERS        = 2'd0;
    localparam logic [1:0] CFG_MAX_NAME_BYTES     = 2'd1;
    localparam logic [1:0] CFG_MAX_HEADER_PAYLOAD = 2'd2;
    localparam logic [1:0] CFG_MAX_TOTAL_BYTES    = 2'd3;

    localparam logic [6:0]  RST_MAX_HEADERS        = 7'd64;
    localparam logic [31:0] RST_MAX_NAME_BYTES     = 32'd32767;
    localparam logic [31:0] RST_MAX_HEADER_PAYLOAD = 32'd1048576;
    localparam logic [31:0] RST_MAX_TOTAL_BYTES    = 32'd1048576;

    // Largest byte string length the format can carry
    localparam logic [31:0] LEN_LIMIT = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  attributes;
        logic [63:0] ts_delta;
        logic [31:0] offset_delta;
        logic [7:0]  header_count;
        logic        key_present;
        logic [31:0] key_length;
        logic        value_present;
        logic [31:0] value_length;
        logic [31:0] name_length;
    } item_t;

    typedef struct packed {
        logic [6:0]  max_headers;
        logic [31:0] max_name_bytes;
        logic [31:0] max_header_payload;
        logic [31:0] max_total_bytes;
    } limits_t;

    // Record totals handed to the final sizing stage
    typedef struct packed {
        status_t     status;
        logic [47:0] body;
        logic [31:0] header_payload;
    } snap_t;

    // LEB128 byte count: one byte per started group of 7 bits
    function automatic logic [3:0] varint_len(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if ((v >> (7 * k)) != 64'd0) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: src/resc_accum.sv
`timescale 1ns / 1ps

module resc_accum
    import resc_pkg::*;
#(
    parameter int MAX_HEADERS = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  limits_t lim,
    output logic    emit,
    output snap_t   snap
);

    localparam logic [7:0] HDR_CAP = 8'(MAX_HEADERS);

    logic [47:0] body_total_reg, body_total_next;
    logic [31:0] hp_total_reg, hp_total_next;
    logic [7:0]  headers_left_reg, headers_left_next;
    status_t     first_error_reg, first_error_next;
    logic        record_open_reg, record_open_next;

    // Record start sizing
    logic [63:0] zz;
    logic [7:0]  hdr_limit;
    logic [31:0] key_size;
    logic [31:0] val_bytes;
    logic [33:0] start_sum;
    status_t     start_err;

    // Header sizing
    logic [32:0] payload;
    logic [33:0] hsum;
    logic [31:0] hval_bytes;
    logic [48:0] hbody;
    status_t     hdr_err;

    always_comb
    begin
        zz = {item.ts_delta[62:0], 1'b0} ^ {64{item.ts_delta[63]}};
        hdr_limit = ({1'b0, lim.max_headers} < HDR_CAP) ? {1'b0, lim.max_headers} : HDR_CAP;
        key_size = item.key_present
            ? 32'(varint_len({31'd0, item.key_length, 1'b0})) + item.key_length
            : 32'd1;
        val_bytes = item.value_present
            ? 32'(varint_len({31'd0, item.value_length, 1'b0})) + item.value_length
            : 32'd1;
        start_sum = 34'd1
            + 34'(varint_len(zz))
            + 34'(varint_len({32'd0, item.offset_delta}))
            + 34'(varint_len({56'd0, item.header_count}))
            + 34'(key_size)
            + 34'(val_bytes);

        priority if (item.attributes != 8'd0)
            start_err = ST_UNSUPPORTED;
        else if (item.header_count > hdr_limit)
            start_err = ST_EXHAUSTED;
        else if (item.key_present && (item.key_length > LEN_LIMIT))
            start_err = ST_RANGE;
        else if (item.value_present && (item.value_length > LEN_LIMIT))
            start_err = ST_RANGE;
        else
            start_err = ST_OK;
    end

    always_comb
    begin
        payload = {1'b0, item.name_length}
            + (item.value_present ? {1'b0, item.value_length} : 33'd0);
        hsum = {2'd0, hp_total_reg} + {1'b0, payload};
        // an absent header value still costs its one-byte null length
        hval_bytes = val_bytes;
        hbody = {1'b0, body_total_reg}
            + 49'(varint_len({32'd0, item.name_length}))
            + 49'(item.name_length)
            + 49'(hval_bytes);

        priority if (item.name_length > lim.max_name_bytes)
            hdr_err = ST_EXHAUSTED;
        else if (payload > {1'b0, lim.max_header_payload})
            hdr_err = ST_EXHAUSTED;
        else if (hsum > {2'd0, lim.max_header_payload})
            hdr_err = ST_EXHAUSTED;
        else if (item.value_present && (item.value_length > LEN_LIMIT))
            hdr_err = ST_RANGE;
        else if (hbody[48])
            hdr_err = ST_RANGE;
        else
            hdr_err = ST_OK;
    end

    always_comb
    begin
        body_total_next   = body_total_reg;
        hp_total_next     = hp_total_reg;
        headers_left_next = headers_left_reg;
        first_error_next  = first_error_reg;
        record_open_next  = record_open_reg;
        emit              = 1'b0;

        if (item.op == OP_START) begin
            body_total_next   = (start_err == ST_OK) ? {14'd0, start_sum} : 48'd0;
            hp_total_next     = 32'd0;
            first_error_next  = start_err;
            headers_left_next = item.header_count;
            record_open_next  = (item.header_count != 8'd0);
            emit              = (item.header_count == 8'd0);
        end
        else if (record_open_reg) begin
            if (first_error_reg == ST_OK) begin
                first_error_next = hdr_err;
                if (hdr_err == ST_OK) begin
                    body_total_next = hbody[47:0];
                    hp_total_next   = hsum[31:0];
                end
            end
            headers_left_next = headers_left_reg - 8'd1;
            if (headers_left_reg == 8'd1) begin
                emit             = 1'b1;
                record_open_next = 1'b0;
            end
        end

        snap.status         = first_error_next;
        snap.body           = body_total_next;
        snap.header_payload = hp_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            body_total_reg   <= '0;
            hp_total_reg     <= '0;
            headers_left_reg <= '0;
            first_error_reg  <= ST_OK;
            record_open_reg  <= 1'b0;
        end
        else if (step) begin
            body_total_reg   <= body_total_next;
            hp_total_reg     <= hp_total_next;
            headers_left_reg <= headers_left_next;
            first_error_reg  <= first_error_next;
            record_open_reg  <= record_open_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_open_has_headers: assert property (@(posedge clk) disable iff (!rst_n)
        record_open_reg |-> headers_left_reg != 8'd0)
        else $error("open record with no headers left");

    a_closed_no_headers: assert property (@(posedge clk) disable iff (!rst_n)
        !record_open_reg |-> headers_left_reg == 8'd0)
        else $error("closed record still counts headers");

    a_error_freezes_body: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.op == OP_HEADER && first_error_reg != ST_OK)
        |=> $stable(body_total_reg) && $stable(hp_total_reg))
        else $error("totals moved after a sticky error");
`endif

endmodule

FILE: src/record_encoded_size_checker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    op .. name_length
// result    out        out_valid / out_ready  status, body_size, encoded_size,
//                                             hdr_payload_size
// config    in         cfg_wr_en              cfg_addr, cfg_wdata
//
// One item per cycle unless a finished record waits on a stalled result: input
// register, record update into the totals register, then length-prefix sizing
// and the limit check into the output register, which raises out_valid.
// Reset clears the record state and pipeline valids and loads the default limits.
// A stalled result holds the pipeline only where an item would produce a result.
module record_encoded_size_checker
    import resc_pkg::*;
#(
    parameter int MAX_HEADERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  attributes,
    input  logic [63:0] ts_delta,
    input  logic [31:0] offset_delta,
    input  logic [7:0]  header_count,
    input  logic        key_present,
    input  logic [31:0] key_length,
    input  logic        value_present,
    input  logic [31:0] value_length,
    input  logic [31:0] name_length,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [47:0] body_size,
    output logic [32:0] encoded_size,
    output logic [31:0] hdr_payload_size
);

    limits_t     lim_reg;

    logic        inq_valid_reg;
    item_t       inq_reg;

    logic        snap_valid_reg;
    snap_t       snap_reg;

    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [47:0] body_reg;
    logic [32:0] enc_reg, enc_next;
    logic [31:0] hp_reg;

    logic        emit;
    snap_t       snap_next;
    logic        out_take;
    logic        snap_move;
    logic        snap_free;
    logic        process;
    logic [32:0] fin_enc;

    assign out_take  = !out_valid_reg || out_ready;
    assign snap_move = snap_valid_reg && out_take;
    assign snap_free = !snap_valid_reg || snap_move;
    assign process   = inq_valid_reg && (!emit || snap_free);
    assign in_ready  = !inq_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lim_reg.max_headers        <= RST_MAX_HEADERS;
            lim_reg.max_name_bytes     <= RST_MAX_NAME_BYTES;
            lim_reg.max_header_payload <= RST_MAX_HEADER_PAYLOAD;
            lim_reg.max_total_bytes    <= RST_MAX_TOTAL_BYTES;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_HEADERS:        lim_reg.max_headers        <= cfg_wdata[6:0];
                CFG_MAX_NAME_BYTES:     lim_reg.max_name_bytes     <= cfg_wdata;
                CFG_MAX_HEADER_PAYLOAD: lim_reg.max_header_payload <= cfg_wdata;
                CFG_MAX_TOTAL_BYTES:    lim_reg.max_total_bytes    <= cfg_wdata;
                default:                lim_reg                    <= lim_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inq_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            inq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            inq_reg <= '{op:              op,
                         attributes:      attributes,
                         ts_delta:        ts_delta,
                         offset_delta:    offset_delta,
                         header_count:    header_count,
                         key_present:     key_present,
                         key_length:      key_length,
                         value_present:   value_present,
                         value_length:    value_length,
                         name_length:     name_length};
        end
    end

    resc_accum #(
        .MAX_HEADERS (MAX_HEADERS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process),
        .item  (inq_reg),
        .lim   (lim_reg),
        .emit  (emit),
        .snap  (snap_next)
    );

    // Completed record totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_free) begin
            snap_valid_reg <= process && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_free && process && emit) begin
            snap_reg <= snap_next;
        end
    end

    // Length prefix and total limit
    always_comb
    begin
        fin_enc = {1'b0, snap_reg.body[31:0]} + 33'(varint_len({16'd0, snap_reg.body}));
        priority if (snap_reg.status != ST_OK) begin
            status_next = snap_reg.status;
            enc_next    = 33'd0;
        end
        else if (snap_reg.body[47:32] != 16'd0) begin
            status_next = ST_RANGE;
            enc_next    = 33'd0;
        end
        else if (fin_enc > {1'b0, lim_reg.max_total_bytes}) begin
            status_next = ST_EXHAUSTED;
            enc_next    = 33'd0;
        end
        else begin
            status_next = ST_OK;
            enc_next    = fin_enc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take) begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_move) begin
            status_reg <= status_next;
            body_reg   <= snap_reg.body;
            enc_reg    <= enc_next;
            hp_reg     <= snap_reg.header_payload;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign body_size        = body_reg;
    assign encoded_size     = enc_reg;
    assign hdr_payload_size = hp_reg;

`ifndef NO_ASSERTIONS
    a_ok_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OK)
        |-> (enc_reg != 33'd0) && (enc_reg <= {1'b0, lim_reg.max_total_bytes}))
        else $error("ok result outside the total limit");

    a_err_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> enc_reg == 33'd0)
        else $error("failed record carries an encoded size");

    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !out_take) |=> snap_valid_reg && $stable(snap_reg))
        else $error("pending record totals lost under stall");
`endif

endmodule
